// ===== sv/fdr_pkg.sv =====
// Shared constants and types of the frame dirty rectangle detector.
package fdr_pkg;

   // Largest frame the detector handles, per axis.
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   // Position counters and bounding box corners.
   localparam int POS_W  = 11;
   // Frame and rectangle sizes, configuration data.
   localparam int DIM_W  = 12;
   localparam int CFG_W  = 12;
   localparam int AREA_W = 2 * DIM_W;

   localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1920);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1080);

   localparam int PIXEL_W     = 32;
   localparam int REQ_TDATA_W = 2 * PIXEL_W;
   // changed + rect_x + rect_y + rect_w + rect_h = 47 bits, padded to 48.
   localparam int RSP_TDATA_W = 48;

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LINE_LEN   = 1'b0,
      REG_LINE_COUNT = 1'b1
   } csr_index_type;

endpackage

// ===== sv/frame_dirty_rect_detector_unit.sv =====
// Frame dirty rectangle detector: bounding box of changed pixels per frame.
//
//  channel  | dir | handshake             | content
//  ---------+-----+-----------------------+-------------------------------------------
//  req_     | in  | req_tvalid/req_tready | one pixel pair per beat, raster order
//  rsp_     | out | rsp_tvalid/rsp_tready | one beat per frame: changed flag + rectangle
//  csr_     | in  | csr_wr_en             | pixels per row (index 0), rows (index 1)
//
// One pixel pair per clock unless a frame end stalls. A beat runs through three
// registers: the input register (compare and bounding box update), the frame
// end register (margin and clipping) and the output register (area test against
// three quarters of the frame area), which drives rsp_tvalid. Reset is
// synchronous and active high; it loads 1920 x 1080 and clears the counters and
// box. A stalled result holds the output register; pixels keep flowing until a
// second frame end finds the frame end register still occupied. A register
// write restarts the frame.
module frame_dirty_rect_detector_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [fdr_pkg::CSR_IDX_W-1:0]         csr_addr,
   input  logic [fdr_pkg::CFG_W-1:0]             csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [31:0] curr_pixel, [63:32] prev_pixel
   input  logic [fdr_pkg::REQ_TDATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] changed, [11:1] rect_x, [22:12] rect_y, [34:23] rect_w, [46:35] rect_h,
   // [47] zero
   output logic [fdr_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import fdr_pkg::*;

   // Configuration and derived frame geometry
   logic [CFG_W-1:0]  cfg_width_ff, cfg_height_ff;
   logic [DIM_W-1:0]  w_eff, h_eff;
   logic [AREA_W-1:0] total_ff, thresh_ff;
   logic [AREA_W+1:0] thresh_in;
   logic              csr_hit;

   // Input register
   logic               s1_valid_ff;
   logic [PIXEL_W-1:0] s1_curr_ff, s1_prev_ff;

   // Frame state
   logic [POS_W-1:0] col_ff, row_ff;
   logic             found_ff;
   logic [POS_W-1:0] least_col_ff, greatest_col_ff, least_row_ff, greatest_row_ff;
   logic             found_in;
   logic [POS_W-1:0] least_col_in, greatest_col_in, least_row_in, greatest_row_in;

   logic             pix_diff, last_col, last_row, frame_end;
   logic             s1_go, s2_free, out_free;
   logic [POS_W-1:0] rx_in, ry_in;
   logic [DIM_W-1:0] gc_plus2, gr_plus2, rw_in, rh_in;

   // Frame end register
   logic             s2_valid_ff, s2_found_ff;
   logic [POS_W-1:0] s2_rx_ff, s2_ry_ff;
   logic [DIM_W-1:0] s2_rw_ff, s2_rh_ff;

   // Output register
   logic                   out_valid_ff;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic [AREA_W-1:0]      area;

   // Clamp the programmed size to 1 .. max.
   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = DIM_W'(1);
      end else if (cfg_width_ff > MAX_W_DIM) begin
         w_eff = MAX_W_DIM;
      end else begin
         w_eff = cfg_width_ff;
      end
      if (cfg_height_ff == '0) begin
         h_eff = DIM_W'(1);
      end else if (cfg_height_ff > MAX_H_DIM) begin
         h_eff = MAX_H_DIM;
      end else begin
         h_eff = cfg_height_ff;
      end
   end

   always_comb begin
      case (csr_index_type'(csr_addr))
         REG_LINE_LEN:   csr_hit = csr_wr_en;
         REG_LINE_COUNT: csr_hit = csr_wr_en;
         default:        csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RESET;
         cfg_height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_addr))
            REG_LINE_LEN:   cfg_width_ff  <= csr_wdata;
            REG_LINE_COUNT: cfg_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame area and its three-quarter threshold follow via total_ff, then thresh_ff;
   // the user must write only while idle (unenforced), so both are settled before use.
   assign thresh_in = ({2'b00, total_ff} + {1'b0, total_ff, 1'b0}) >> 2;

   always_ff @(posedge clock) begin
      total_ff  <= AREA_W'(w_eff) * AREA_W'(h_eff);
      thresh_ff <= thresh_in[AREA_W-1:0];
   end

   // Handshake: each stage advances when the one after it can take its beat.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_go      = s1_valid_ff && (!frame_end || s2_free);
   assign req_tready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_curr_ff <= req_tdata[PIXEL_W-1:0];
         s1_prev_ff <= req_tdata[REQ_TDATA_W-1:PIXEL_W];
      end
   end

   // Widen the box with a differing pixel.
   assign pix_diff = s1_curr_ff != s1_prev_ff;

   always_comb begin
      found_in        = found_ff;
      least_col_in    = least_col_ff;
      greatest_col_in = greatest_col_ff;
      least_row_in    = least_row_ff;
      greatest_row_in = greatest_row_ff;
      if (pix_diff) begin
         found_in = 1'b1;
         if (!found_ff) begin
            least_col_in    = col_ff;
            greatest_col_in = col_ff;
            least_row_in    = row_ff;
         end else begin
            if (col_ff < least_col_ff) begin
               least_col_in = col_ff;
            end
            if (col_ff > greatest_col_ff) begin
               greatest_col_in = col_ff;
            end
         end
         greatest_row_in = row_ff;
      end
   end

   assign last_col  = ({1'b0, col_ff} + DIM_W'(1)) >= w_eff;
   assign last_row  = ({1'b0, row_ff} + DIM_W'(1)) >= h_eff;
   assign frame_end = last_col && last_row;

   // One-pixel margin, clipped to the frame.
   assign rx_in    = (least_col_in != '0) ? least_col_in - POS_W'(1) : '0;
   assign ry_in    = (least_row_in != '0) ? least_row_in - POS_W'(1) : '0;
   assign gc_plus2 = {1'b0, greatest_col_in} + DIM_W'(2);
   assign gr_plus2 = {1'b0, greatest_row_in} + DIM_W'(2);
   assign rw_in    = (gc_plus2 < w_eff) ? gc_plus2 - {1'b0, rx_in} : w_eff - {1'b0, rx_in};
   assign rh_in    = (gr_plus2 < h_eff) ? gr_plus2 - {1'b0, ry_in} : h_eff - {1'b0, ry_in};

   always_ff @(posedge clock) begin
      if (reset || csr_hit || (s1_go && frame_end)) begin
         // Restart the frame.
         col_ff          <= '0;
         row_ff          <= '0;
         found_ff        <= 1'b0;
         least_col_ff    <= '0;
         greatest_col_ff <= '0;
         least_row_ff    <= '0;
         greatest_row_ff <= '0;
      end else if (s1_go) begin
         found_ff        <= found_in;
         least_col_ff    <= least_col_in;
         greatest_col_ff <= greatest_col_in;
         least_row_ff    <= least_row_in;
         greatest_row_ff <= greatest_row_in;
         if (!last_col) begin
            col_ff <= col_ff + POS_W'(1);
         end else begin
            col_ff <= '0;
            row_ff <= row_ff + POS_W'(1);
         end
      end
   end

   // Frame end register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_go && frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && frame_end) begin
         s2_found_ff <= found_in;
         s2_rx_ff    <= rx_in;
         s2_ry_ff    <= ry_in;
         s2_rw_ff    <= rw_in;
         s2_rh_ff    <= rh_in;
      end
   end

   // Report the full frame when the box covers more than three quarters.
   assign area = AREA_W'(s2_rw_ff) * AREA_W'(s2_rh_ff);

   always_comb begin
      out_data_in = '0;
      if (s2_found_ff) begin
         out_data_in[0] = 1'b1;
         if (area > thresh_ff) begin
            out_data_in[34:23] = w_eff;
            out_data_in[46:35] = h_eff;
         end else begin
            out_data_in[11:1]  = s2_rx_ff;
            out_data_in[22:12] = s2_ry_ff;
            out_data_in[34:23] = s2_rw_ff;
            out_data_in[46:35] = s2_rh_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // An unchanged frame reports an all-zero rectangle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[RSP_TDATA_W-1:1] == '0)
      else $error("unchanged frame with nonzero rectangle");

   // The column counter never leaves the frame.
   assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < w_eff)
      else $error("column counter beyond frame width");

   // A held box always lies within the frame width.
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_found_ff |-> ({2'b00, s2_rx_ff} + {1'b0, s2_rw_ff}) <= {1'b0, w_eff})
      else $error("rectangle exceeds frame width");

   // A frame end waiting on a full frame end register must not advance.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && frame_end && !s2_free |=> s1_valid_ff && $stable(row_ff))
      else $error("frame end dropped under stall");

endmodule

// ===== sim/fdr_rect_checker.sv =====
// Scoreboard for the dirty rectangle detector: predicts each frame result and checks rsp beats.
`timescale 1ns / 100ps

module fdr_rect_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [fdr_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  logic [fdr_pkg::CFG_W-1:0]       csr_wdata,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [fdr_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [fdr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                              mismatch_count,
   output int                              rects_pending
);
   import fdr_pkg::*;

   // Declared high field first so that bit 0 is the changed flag, as on rsp_tdata.
   typedef struct packed {
      logic [DIM_W-1:0] h;
      logic [DIM_W-1:0] w;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] x;
      logic             changed;
   } dirty_rect_type;

   localparam int REPORT_CAP = 100;

   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   logic [POS_W-1:0] col_pos;
   logic [POS_W-1:0] row_pos;
   logic             seen_change;
   logic [DIM_W-1:0] left_col;
   logic [POS_W-1:0] right_col;
   logic [DIM_W-1:0] top_row;
   logic [POS_W-1:0] bottom_row;
   dirty_rect_type   rects_due[$];
   int               rects_checked;

   function automatic int unsigned usable_dim(input logic [CFG_W-1:0] raw,
                                              input logic [DIM_W-1:0] limit);
      if (raw == '0) return 1;
      if (raw > limit) return limit;
      return raw;
   endfunction

   task automatic clear_frame();
      col_pos     = '0;
      row_pos     = '0;
      seen_change = 1'b0;
      left_col    = '0;
      right_col   = '0;
      top_row     = '0;
      bottom_row  = '0;
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_CAP) $display("MISMATCH: %s", what);
      mismatch_count++;
   endtask

   task automatic compare_field(input string field, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("frame result %0d field %s: got %0d, want %0d",
                                   rects_checked, field, got, want));
   endtask

   // Widen the box on a differing pair, advance the raster position and
   // queue the rectangle at the last pixel of the frame.
   task automatic track_pixel(input logic [PIXEL_W-1:0] cur, input logic [PIXEL_W-1:0] prv);
      int unsigned     fw, fh, x, y, rx, ry, rw, rh;
      longint unsigned area, total;
      dirty_rect_type  rect;
      fw = usable_dim(width_reg, MAX_W_DIM);
      fh = usable_dim(height_reg, MAX_H_DIM);
      x  = col_pos;
      y  = row_pos;
      if (cur != prv) begin
         if (!seen_change) begin
            seen_change = 1'b1;
            left_col    = DIM_W'(x);
            right_col   = POS_W'(x);
            top_row     = DIM_W'(y);
         end
         if (x < left_col) left_col = DIM_W'(x);
         if (x > right_col) right_col = POS_W'(x);
         bottom_row = POS_W'(y);
      end
      if (x + 1 < fw) begin
         col_pos = POS_W'(x + 1);
      end else if (y + 1 < fh) begin
         col_pos = '0;
         row_pos = POS_W'(y + 1);
      end else begin
         rect = '0;
         if (seen_change) begin
            rx = (left_col > 0) ? left_col - 1 : 0;
            ry = (top_row > 0) ? top_row - 1 : 0;
            rw = (right_col + 2 < fw) ? right_col + 2 - rx : fw - rx;
            rh = (bottom_row + 2 < fh) ? bottom_row + 2 - ry : fh - ry;
            area  = longint'(rw) * longint'(rh);
            total = longint'(fw) * longint'(fh);
            if (area > (total * 3) / 4) begin
               rx = 0;
               ry = 0;
               rw = fw;
               rh = fh;
            end
            rect.changed = 1'b1;
            rect.x       = POS_W'(rx);
            rect.y       = POS_W'(ry);
            rect.w       = DIM_W'(rw);
            rect.h       = DIM_W'(rh);
         end
         rects_due.push_back(rect);
         clear_frame();
      end
   endtask

   task automatic check_rect(input logic [RSP_TDATA_W-1:0] beat);
      dirty_rect_type got, want;
      got = beat[$bits(dirty_rect_type)-1:0];
      if (rects_due.size() == 0) begin
         report_mismatch($sformatf(
            "rsp beat with no frame result due: changed %0d x %0d y %0d w %0d h %0d",
            got.changed, got.x, got.y, got.w, got.h));
      end else begin
         want = rects_due.pop_front();
         compare_field("changed", got.changed, want.changed);
         compare_field("rect_x", got.x, want.x);
         compare_field("rect_y", got.y, want.y);
         compare_field("rect_w", got.w, want.w);
         compare_field("rect_h", got.h, want.h);
      end
      rects_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         clear_frame();
         rects_due.delete();
      end else begin
         // Any register write restarts the frame.
         if (csr_wr_en) begin
            if (csr_addr == REG_LINE_LEN) width_reg = csr_wdata;
            else if (csr_addr == REG_LINE_COUNT) height_reg = csr_wdata;
            clear_frame();
         end
         if (req_tvalid && req_tready)
            track_pixel(req_tdata[PIXEL_W-1:0], req_tdata[2*PIXEL_W-1:PIXEL_W]);
         if (rsp_tvalid && rsp_tready)
            check_rect(rsp_tdata);
      end
      rects_pending <= rects_due.size();
   end

endmodule

// ===== sim/testbench.sv =====
// Top of the dirty rectangle detector bench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
   import fdr_pkg::*;

   // Keep adding random phases until at least this many pixel beats have gone out.
   localparam int TOTAL_ITEMS     = 1800;
   // Keep going until at least this many frame results have come back.
   localparam int MIN_RESULTS     = 40;
   // Percent of cycles each side idles.
   localparam int IDLE_PCT        = 28;
   // Cycles to let the pipeline empty before a register write.
   localparam int DRAIN_CYCLES    = 8;
   // Long receiver hold-off that backs the detector up into its input.
   localparam int HOLD_OFF_CYCLES = 400;
   // Cycles without any beat that end the run; several times the hold-off.
   localparam int WATCHDOG_LIMIT  = 4000;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_addr   = '0;
   logic [CFG_W-1:0]       csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int mismatch_count;
   int rects_pending;

   // Frame geometry in force, as the detector clamps it.
   int frame_w = 1920;
   int frame_h = 1080;

   int quiet_cycles    = 0;
   int results_seen    = 0;
   int items_sent      = 0;
   bit steady          = 1'b0;
   int hold_off_asks   = 0;
   int hold_off_served = 0;

   frame_dirty_rect_detector_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   fdr_rect_checker rect_check (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .rects_pending  (rects_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: idle at random, never during the steady phase, and serve each
   // hold-off request by keeping rsp_tready low for a long, counted stretch.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_served != hold_off_asks) begin
            hold_off_served++;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog: count cycles without a beat on either channel, and count results.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (rsp_tvalid && rsp_tready) results_seen <= results_seen + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Offer one pixel pair, with random idle cycles ahead of it, and hold it
   // until the beat is taken. Returns at the accepting edge.
   task automatic send_pixel(input logic [PIXEL_W-1:0] cur, input logic [PIXEL_W-1:0] prv);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom};
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {prv, cur};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Drop the input, wait for every frame result, then let the pipeline empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rects_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both geometry registers, in random order, once the detector is idle.
   task automatic set_dims(input int raw_w, input int raw_h);
      bit width_first;
      width_first = $urandom_range(1);
      settle();
      csr_wr_en <= 1'b1;
      csr_addr  <= width_first ? REG_LINE_LEN : REG_LINE_COUNT;
      csr_wdata <= CFG_W'(width_first ? raw_w : raw_h);
      @(posedge clock);
      csr_addr  <= width_first ? REG_LINE_COUNT : REG_LINE_LEN;
      csr_wdata <= CFG_W'(width_first ? raw_h : raw_w);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frame_w = (raw_w == 0) ? 1 : (raw_w > MAX_WIDTH) ? MAX_WIDTH : raw_w;
      frame_h = (raw_h == 0) ? 1 : (raw_h > MAX_HEIGHT) ? MAX_HEIGHT : raw_h;
   endtask

   // Send the first n pixels of a frame in raster order. The change pattern is
   // picked per frame: none, one pixel, sparse, dense, or a sub-rectangle.
   task automatic send_frame_pixels(input int n);
      int                 style, rate, k, x, y;
      int                 left, right, top, bottom;
      bit                 differs;
      logic [PIXEL_W-1:0] cur, mask;
      style = $urandom_range(99);
      rate  = (style < 55) ? $urandom_range(25, 1) : $urandom_range(100, 60);
      // Bias the box corners toward the frame edges to hit the margin clipping.
      case ($urandom_range(3))
         0:       left = 0;
         1:       left = frame_w - 1;
         default: left = $urandom_range(frame_w - 1);
      endcase
      case ($urandom_range(3))
         0:       top = 0;
         1:       top = frame_h - 1;
         default: top = $urandom_range(frame_h - 1);
      endcase
      right  = ($urandom_range(2) == 0) ? frame_w - 1 : $urandom_range(frame_w - 1, left);
      bottom = ($urandom_range(2) == 0) ? frame_h - 1 : $urandom_range(frame_h - 1, top);
      for (k = 0; k < n; k++) begin
         x = k % frame_w;
         y = k / frame_w;
         if (style < 15) differs = 1'b0;
         else if (style < 35) differs = (x == left && y == top);
         else if (style < 75) differs = ($urandom_range(99) < rate);
         else differs = (x == left && y == top) || (x == right && y == bottom) ||
                        (x >= left && x <= right && y >= top && y <= bottom &&
                         $urandom_range(3) == 0);
         case ($urandom_range(9))
            0:       cur = '0;
            1:       cur = '1;
            default: cur = $urandom;
         endcase
         case ($urandom_range(4))
            0:       mask = '1;
            1:       mask = 32'd1 << $urandom_range(31);
            default: mask = $urandom;
         endcase
         if (mask == '0) mask = 32'h8000_0000;
         send_pixel(cur, differs ? cur ^ mask : cur);
      end
   endtask

   initial begin : stimulus
      int phase, frames, area, raw_w, raw_h, pick, cut;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A partial frame at the reset geometry; the register writes drop it.
      send_pixel(32'h0000_0000, 32'h0000_0000);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(32'h1234_5678, 32'h1234_5678);
      set_dims(3, 2);

      // Unchanged frame: all rectangle fields zero.
      send_pixel(32'h0000_0000, 32'h0000_0000);
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(32'hA5A5_5A5A, 32'hA5A5_5A5A);
      send_pixel(32'h0000_0001, 32'h0000_0001);
      send_pixel(32'h8000_0000, 32'h8000_0000);
      send_pixel(32'h0F0F_F0F0, 32'h0F0F_F0F0);

      // Change at the top-left pixel: margin floored at zero.
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
      send_pixel(32'h1111_1111, 32'h1111_1111);
      send_pixel(32'h2222_2222, 32'h2222_2222);
      send_pixel(32'h3333_3333, 32'h3333_3333);
      send_pixel(32'h4444_4444, 32'h4444_4444);
      send_pixel(32'h5555_5555, 32'h5555_5555);

      // Change at the bottom-right pixel: margin clamped to the frame edge.
      send_pixel(32'h6666_6666, 32'h6666_6666);
      send_pixel(32'h7777_7777, 32'h7777_7777);
      send_pixel(32'h9999_9999, 32'h9999_9999);
      send_pixel(32'hAAAA_AAAA, 32'hAAAA_AAAA);
      send_pixel(32'hBBBB_BBBB, 32'hBBBB_BBBB);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);

      // Zero geometry runs as 1 x 1: every beat ends a frame, a change fills it.
      set_dims(0, 0);
      send_pixel(32'hC3C3_C3C3, 32'hC3C3_C3C3);
      send_pixel(32'hFFFF_FFFF, 32'h7FFF_FFFF);

      // Random phases. Two fixed ones: the long hold-off, and the widest
      // geometry, clamped from above, sent as a steady stretch without idling.
      phase = 0;
      while (phase <= 6 || items_sent < TOTAL_ITEMS || results_seen < MIN_RESULTS) begin
         steady = (phase == 2);
         case (phase)
            2: begin
               set_dims(4095, 0);
               send_frame_pixels(frame_w * frame_h);
            end
            default: begin
               pick = $urandom_range(99);
               if (phase == 1) begin
                  raw_w = 1;
                  raw_h = 1;
               end else if (pick < 60) begin
                  raw_w = $urandom_range(8);
                  raw_h = $urandom_range(8);
               end else if (pick < 80) begin
                  raw_w = $urandom_range(40, 1);
                  raw_h = $urandom_range(4);
               end else begin
                  raw_w = $urandom_range(4);
                  raw_h = $urandom_range(40, 1);
               end
               set_dims(raw_w, raw_h);
               // Back the receiver off while single-pixel frames keep coming.
               if (phase == 1) hold_off_asks++;
               area   = frame_w * frame_h;
               frames = (phase == 1) ? 40 : 1 + $urandom_range(40 / area);
               repeat (frames) send_frame_pixels(area);
               // Now and then leave a frame unfinished; the next write restarts it.
               if (area > 1 && $urandom_range(4) == 0) begin
                  cut = $urandom_range(area - 1, 1);
                  send_frame_pixels(cut);
               end
            end
         endcase
         phase++;
      end

      settle();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/fdr_pkg.sv
sv/frame_dirty_rect_detector_unit.sv
sim/fdr_rect_checker.sv
sim/testbench.sv
